// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/evsd_pkg.sv -----
package evsd_pkg;

   // word layout
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TYPE_W  = 4;
   localparam int unsigned PAY_W   = 28;
   localparam int unsigned BASE_W  = 28;
   localparam int unsigned FINE_W  = 6;
   localparam int unsigned COORD_W = 11;
   localparam int unsigned COL_W   = 12;
   localparam int unsigned CHAN_W  = 5;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned OUT_TIME_W = 64;
   localparam int unsigned WRAP_SHIFT = 34;

   // queue between front and back
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   // word type codes
   localparam logic [TYPE_W-1:0] TYPE_TRIGGER   = 4'h9;
   localparam logic [TYPE_W-1:0] TYPE_EVENT_OFF = 4'hA;
   localparam logic [TYPE_W-1:0] TYPE_EVENT_ON  = 4'hB;
   localparam logic [TYPE_W-1:0] TYPE_VECT_OFF  = 4'hC;
   localparam logic [TYPE_W-1:0] TYPE_VECT_ON   = 4'hD;
   localparam logic [TYPE_W-1:0] TYPE_TIME_HIGH = 4'hE;

   // result kinds
   localparam logic KIND_EVENT   = 1'b0;
   localparam logic KIND_TRIGGER = 1'b1;

   // one classified command from front to back
   typedef struct packed {
      logic                    kind;
      logic                    vector;
      logic [OUT_TIME_W-1:0]   event_time;
      logic [COORD_W-1:0]      column;
      logic [COORD_W-1:0]      row;
      logic                    polarity;
      logic [CHAN_W-1:0]       channel;
      logic [WORD_W-1:0]       mask;
   } cmd_type;

endpackage

// ----- sv/event_camera_word_stream_decoder.sv -----
// Decodes a stream of 32-bit event-camera words into change events and trigger
// results. The front takes one word per cycle while the queue is not full,
// keeps the time base and wrap count, holds a vector base until its mask word
// arrives, and hands each word that yields results to a four-entry queue; words
// that yield nothing (time high, padding, vector base, zero mask) never reach
// the queue. The back turns each queued word into results at one result per
// cycle while rsp_stall is low, through a registered output stage: single
// events and triggers give one result, a vector mask gives one result per set
// bit, lowest bit first. req_stall rises only when the queue is full, so a
// burst of masks slows the input only once it fills the queue. Timestamps are
// TIME_WIDTH bits wide, zero-extended to 64 on the output, and wrap at
// 2^TIME_WIDTH. Reset is synchronous; no clearing pass follows it.
`include "assert_macros.svh"

module event_camera_word_stream_decoder #(
   parameter int unsigned TIME_WIDTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [evsd_pkg::WORD_W-1:0]     req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [evsd_pkg::OUT_TIME_W-1:0] rsp_event_time,
   output logic [evsd_pkg::COL_W-1:0]      rsp_column,
   output logic [evsd_pkg::COORD_W-1:0]    rsp_row,
   output logic                            rsp_polarity,
   output logic [evsd_pkg::CHAN_W-1:0]     rsp_trigger_channel,
   output logic                            rsp_last
);

   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;
   evsd_pkg::cmd_type q_cmd;
   evsd_pkg::cmd_type q_head;

   // word classification and time base
   evsd_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // decoupling queue
   evsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   // result generation
   evsd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_event_time      (rsp_event_time),
      .rsp_column          (rsp_column),
      .rsp_row             (rsp_row),
      .rsp_polarity        (rsp_polarity),
      .rsp_trigger_channel (rsp_trigger_channel),
      .rsp_last            (rsp_last)
   );

   // checks
   `ASSERT_IMPLIES(a_queue_no_overflow, clock, reset, q_push, !q_full)
   `ASSERT_NEXT(a_queue_holds_word, clock, reset, q_push && !q_pop, !q_empty)
   `ASSERT_IMPLIES(a_trigger_single, clock, reset, rsp_valid && rsp_kind, rsp_last && rsp_column == '0 && rsp_row == '0)
   `ASSERT_IMPLIES(a_event_no_channel, clock, reset, rsp_valid && !rsp_kind, rsp_trigger_channel == '0)

endmodule

// ----- sv/evsd_front.sv -----
module evsd_front #(
   parameter int unsigned TIME_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [evsd_pkg::WORD_W-1:0]  req_word,
   output logic                         req_stall,
   input  logic                         q_full,
   output logic                         q_push,
   output evsd_pkg::cmd_type            q_cmd
);

   localparam int unsigned WRAP_W = TIME_WIDTH - evsd_pkg::WRAP_SHIFT;

   logic [evsd_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [WRAP_W-1:0]            wrap_ff, wrap_in;
   logic                         pend_ff, pend_in;
   logic [TIME_WIDTH-1:0]        pend_time_ff, pend_time_in;
   logic [evsd_pkg::COORD_W-1:0] pend_col_ff, pend_col_in;
   logic [evsd_pkg::COORD_W-1:0] pend_row_ff, pend_row_in;
   logic                         pend_pol_ff, pend_pol_in;

   logic                         accept;
   logic [evsd_pkg::TYPE_W-1:0]  word_code;
   logic [evsd_pkg::PAY_W-1:0]   payload;
   logic [TIME_WIDTH-1:0]        now_time;

   // input side stalls only on a full queue
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign word_code = req_word[evsd_pkg::WORD_W-1 -: evsd_pkg::TYPE_W];
   assign payload   = req_word[evsd_pkg::PAY_W-1:0];
   assign now_time  = {wrap_ff, base_ff, payload[27:22]};

   // classify the word and update the time base
   always_comb begin
      base_in      = base_ff;
      wrap_in      = wrap_ff;
      pend_in      = pend_ff;
      pend_time_in = pend_time_ff;
      pend_col_in  = pend_col_ff;
      pend_row_in  = pend_row_ff;
      pend_pol_in  = pend_pol_ff;
      q_push       = 1'b0;
      q_cmd        = '0;
      if (accept) begin
         if (pend_ff) begin
            // word after a vector base is its mask
            pend_in          = 1'b0;
            q_push           = (req_word != '0);
            q_cmd.kind       = evsd_pkg::KIND_EVENT;
            q_cmd.vector     = 1'b1;
            q_cmd.event_time = evsd_pkg::OUT_TIME_W'(pend_time_ff);
            q_cmd.column     = pend_col_ff;
            q_cmd.row        = pend_row_ff;
            q_cmd.polarity   = pend_pol_ff;
            q_cmd.mask       = req_word;
         end else begin
            case (word_code)
               evsd_pkg::TYPE_EVENT_OFF, evsd_pkg::TYPE_EVENT_ON: begin
                  q_push           = 1'b1;
                  q_cmd.kind       = evsd_pkg::KIND_EVENT;
                  q_cmd.event_time = evsd_pkg::OUT_TIME_W'(now_time);
                  q_cmd.column     = payload[21:11];
                  q_cmd.row        = payload[10:0];
                  q_cmd.polarity   = word_code[0];
               end
               evsd_pkg::TYPE_VECT_OFF, evsd_pkg::TYPE_VECT_ON: begin
                  pend_in      = 1'b1;
                  pend_time_in = now_time;
                  pend_col_in  = payload[21:11];
                  pend_row_in  = payload[10:0];
                  pend_pol_in  = word_code[0];
               end
               evsd_pkg::TYPE_TRIGGER: begin
                  q_push           = 1'b1;
                  q_cmd.kind       = evsd_pkg::KIND_TRIGGER;
                  q_cmd.event_time = evsd_pkg::OUT_TIME_W'(now_time);
                  q_cmd.polarity   = payload[0];
                  q_cmd.channel    = payload[12:8];
               end
               evsd_pkg::TYPE_TIME_HIGH: begin
                  // a backwards step of the base counts one wrap
                  if (payload < base_ff) begin
                     wrap_in = wrap_ff + WRAP_W'(1);
                  end
                  base_in = payload;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         wrap_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         base_ff <= base_in;
         wrap_ff <= wrap_in;
         pend_ff <= pend_in;
      end
   end

   // held vector base
   always_ff @(posedge clock) begin
      pend_time_ff <= pend_time_in;
      pend_col_ff  <= pend_col_in;
      pend_row_ff  <= pend_row_in;
      pend_pol_ff  <= pend_pol_in;
   end

endmodule

// ----- sv/evsd_queue.sv -----
module evsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  evsd_pkg::cmd_type  q_cmd,
   input  logic               q_pop,
   output evsd_pkg::cmd_type  q_head,
   output logic               q_full,
   output logic               q_empty
);

   evsd_pkg::cmd_type                slot_ff [evsd_pkg::Q_DEPTH];
   logic [evsd_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [evsd_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [evsd_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   assign q_full  = (count_ff == evsd_pkg::Q_CNT_W'(evsd_pkg::Q_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + evsd_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + evsd_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      case ({q_push, q_pop})
         2'b10:   count_in = count_ff + evsd_pkg::Q_CNT_W'(1);
         2'b01:   count_in = count_ff - evsd_pkg::Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_cmd;
      end
   end

endmodule

// ----- sv/evsd_back.sv -----
module evsd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  evsd_pkg::cmd_type               q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [evsd_pkg::OUT_TIME_W-1:0] rsp_event_time,
   output logic [evsd_pkg::COL_W-1:0]      rsp_column,
   output logic [evsd_pkg::COORD_W-1:0]    rsp_row,
   output logic                            rsp_polarity,
   output logic [evsd_pkg::CHAN_W-1:0]     rsp_trigger_channel,
   output logic                            rsp_last
);

   evsd_pkg::cmd_type                cur_ff, cur_in;
   logic                             cur_valid_ff, cur_valid_in;

   logic                             out_valid_ff, out_valid_in;
   logic                             out_kind_ff, out_kind_in;
   logic [evsd_pkg::OUT_TIME_W-1:0]  out_time_ff, out_time_in;
   logic [evsd_pkg::COL_W-1:0]       out_col_ff, out_col_in;
   logic [evsd_pkg::COORD_W-1:0]     out_row_ff, out_row_in;
   logic                             out_pol_ff, out_pol_in;
   logic [evsd_pkg::CHAN_W-1:0]      out_chan_ff, out_chan_in;
   logic                             out_last_ff, out_last_in;

   logic                             out_free;
   logic                             emit;
   logic                             done;
   logic [evsd_pkg::IDX_W-1:0]       low_idx;
   logic [evsd_pkg::WORD_W-1:0]      rest_mask;
   logic                             last_word;

   // position of the lowest set bit
   function automatic logic [evsd_pkg::IDX_W-1:0] lowest_set(
      input logic [evsd_pkg::WORD_W-1:0] m
   );
      logic [evsd_pkg::IDX_W-1:0] idx;
      idx = '0;
      for (int i = evsd_pkg::WORD_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = evsd_pkg::IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_free;
   assign low_idx   = lowest_set(cur_ff.mask);
   assign rest_mask = cur_ff.mask & (cur_ff.mask - evsd_pkg::WORD_W'(1));
   assign last_word = !cur_ff.vector || (rest_mask == '0);
   assign done      = emit && last_word;
   assign q_pop     = (!cur_valid_ff || done) && !q_empty;

   // step through the current command
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (emit && cur_ff.vector) begin
         cur_in.mask = rest_mask;
      end
      if (done) begin
         cur_valid_in = 1'b0;
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_time_in  = out_time_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_pol_in   = out_pol_ff;
      out_chan_in  = out_chan_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = cur_ff.kind;
         out_time_in  = cur_ff.event_time;
         out_row_in   = cur_ff.row;
         out_pol_in   = cur_ff.polarity;
         out_chan_in  = cur_ff.channel;
         out_last_in  = last_word;
         if (cur_ff.vector) begin
            out_col_in = evsd_pkg::COL_W'(cur_ff.column) + evsd_pkg::COL_W'(low_idx);
         end else begin
            out_col_in = evsd_pkg::COL_W'(cur_ff.column);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_kind_ff <= out_kind_in;
      out_time_ff <= out_time_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_pol_ff  <= out_pol_in;
      out_chan_ff <= out_chan_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_event_time      = out_time_ff;
   assign rsp_column          = out_col_ff;
   assign rsp_row             = out_row_ff;
   assign rsp_polarity        = out_pol_ff;
   assign rsp_trigger_channel = out_chan_ff;
   assign rsp_last            = out_last_ff;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int TIME_WIDTH  = 64;
   localparam int WRAP_W      = TIME_WIDTH - evsd_pkg::WRAP_SHIFT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   // word types that decode to nothing
   localparam logic [evsd_pkg::TYPE_W-1:0] TYPE_PADDING   = 4'h0;
   localparam logic [evsd_pkg::TYPE_W-1:0] TYPE_CONTINUED = 4'h8;
   localparam logic [evsd_pkg::TYPE_W-1:0] TYPE_OTHER     = 4'hF;

   // one decoded result as seen on the output ports
   typedef struct packed {
      logic                            kind;
      logic [evsd_pkg::OUT_TIME_W-1:0] event_time;
      logic [evsd_pkg::COL_W-1:0]      column;
      logic [evsd_pkg::COORD_W-1:0]    row;
      logic                            polarity;
      logic [evsd_pkg::CHAN_W-1:0]     channel;
      logic                            last;
   } decoded_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [evsd_pkg::WORD_W-1:0]     req_word;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_kind;
   logic [evsd_pkg::OUT_TIME_W-1:0] rsp_event_time;
   logic [evsd_pkg::COL_W-1:0]      rsp_column;
   logic [evsd_pkg::COORD_W-1:0]    rsp_row;
   logic                            rsp_polarity;
   logic [evsd_pkg::CHAN_W-1:0]     rsp_trigger_channel;
   logic                            rsp_last;

   // decoder state mirrored by the testbench
   logic [evsd_pkg::WRAP_SHIFT-1:0] time_base     = '0;
   logic [WRAP_W-1:0]               wrap_count    = '0;
   logic                            vector_held   = 1'b0;
   logic [evsd_pkg::OUT_TIME_W-1:0] held_time     = '0;
   logic [evsd_pkg::COORD_W-1:0]    held_column   = '0;
   logic [evsd_pkg::COORD_W-1:0]    held_row      = '0;
   logic                            held_polarity = 1'b0;

   decoded_type                decoded_q[$];
   logic [evsd_pkg::PAY_W-1:0] stream_base = '0;
   int                         send_idle_pct;
   int                         recv_stall_pct;
   int                         mismatches  = 0;
   int                         cycle_count = 0;

   event_camera_word_stream_decoder #(
      .TIME_WIDTH(TIME_WIDTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_word            (req_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_event_time      (rsp_event_time),
      .rsp_column          (rsp_column),
      .rsp_row             (rsp_row),
      .rsp_polarity        (rsp_polarity),
      .rsp_trigger_channel (rsp_trigger_channel),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // timestamp from wrap count, time base and the fine bits of the payload
   function automatic logic [evsd_pkg::OUT_TIME_W-1:0] stamp(
      input logic [evsd_pkg::PAY_W-1:0] pay
   );
      return (evsd_pkg::OUT_TIME_W'(wrap_count) << evsd_pkg::WRAP_SHIFT)
           | evsd_pkg::OUT_TIME_W'(time_base)
           | evsd_pkg::OUT_TIME_W'(pay[27:22]);
   endfunction

   // decode one accepted word, queueing the results it yields
   function automatic void decode_word(input logic [evsd_pkg::WORD_W-1:0] w);
      logic [evsd_pkg::TYPE_W-1:0]     code;
      logic [evsd_pkg::PAY_W-1:0]      pay;
      logic [evsd_pkg::WRAP_SHIFT-1:0] new_base;
      decoded_type                     r;
      int                              first;
      code  = w[31:28];
      pay   = w[27:0];
      first = decoded_q.size();
      r     = '0;
      if (vector_held) begin
         // this word is the mask of the held vector base
         vector_held = 1'b0;
         for (int b_idx = 0; b_idx < evsd_pkg::WORD_W; b_idx++) begin
            if (w[b_idx]) begin
               r.kind       = evsd_pkg::KIND_EVENT;
               r.event_time = held_time;
               r.column     = {1'b0, held_column} + evsd_pkg::COL_W'(b_idx);
               r.row        = held_row;
               r.polarity   = held_polarity;
               decoded_q.push_back(r);
            end
         end
      end else begin
         case (code)
            evsd_pkg::TYPE_EVENT_OFF, evsd_pkg::TYPE_EVENT_ON: begin
               r.kind       = evsd_pkg::KIND_EVENT;
               r.event_time = stamp(pay);
               r.column     = {1'b0, pay[21:11]};
               r.row        = pay[10:0];
               r.polarity   = code[0];
               decoded_q.push_back(r);
            end
            evsd_pkg::TYPE_VECT_OFF, evsd_pkg::TYPE_VECT_ON: begin
               held_time     = stamp(pay);
               held_column   = pay[21:11];
               held_row      = pay[10:0];
               held_polarity = code[0];
               vector_held   = 1'b1;
            end
            evsd_pkg::TYPE_TRIGGER: begin
               r.kind       = evsd_pkg::KIND_TRIGGER;
               r.event_time = stamp(pay);
               r.polarity   = pay[0];
               r.channel    = pay[12:8];
               decoded_q.push_back(r);
            end
            evsd_pkg::TYPE_TIME_HIGH: begin
               new_base = {pay, {evsd_pkg::FINE_W{1'b0}}};
               if (new_base < time_base) wrap_count = wrap_count + 1'b1;
               time_base = new_base;
            end
            default: ;
         endcase
      end
      // flag the final result of this word
      if (decoded_q.size() > first) begin
         r      = decoded_q.pop_back();
         r.last = 1'b1;
         decoded_q.push_back(r);
      end
   endfunction

   function automatic string describe(input decoded_type r);
      return $sformatf("kind %0d time %h col %0d row %0d pol %0d chan %0d last %0d",
                       r.kind, r.event_time, r.column, r.row, r.polarity, r.channel,
                       r.last);
   endfunction

   task automatic note_mismatch(input decoded_type want, input decoded_type got,
                                input logic orphan);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         if (orphan) $display("result with none expected: %s", describe(got));
         else $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
   endtask

   // predict on accepted words, then check accepted results, at each edge
   always @(posedge clock) begin : monitor
      decoded_type got;
      decoded_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) decode_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_event_time, rsp_column, rsp_row, rsp_polarity,
                   rsp_trigger_channel, rsp_last};
            if (decoded_q.size() == 0) begin
               note_mismatch(got, got, 1'b1);
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) note_mismatch(want, got, 1'b0);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // offer one word, returning just after the edge that takes it
   task automatic send_word(input logic [evsd_pkg::WORD_W-1:0] w);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the input until every predicted result has come out
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   // single events, triggers and ignored types at field extremes
   task automatic test_single_words();
      send_word({evsd_pkg::TYPE_EVENT_OFF, 28'h0000000});
      send_word({evsd_pkg::TYPE_EVENT_ON, 28'hFFFFFFF});
      send_word({evsd_pkg::TYPE_TRIGGER, 6'h3F, 9'h000, 5'h1F, 7'h00, 1'b1});
      send_word({evsd_pkg::TYPE_TRIGGER, 28'h0000000});
      send_word({TYPE_PADDING, 28'hFFFFFFF});
      send_word({TYPE_CONTINUED, 28'hFFFFFFF});
      send_word({TYPE_OTHER, 28'hFFFFFFF});
   endtask

   // time base at its top, a backwards step that wraps, an equal step that does not
   task automatic test_time_base();
      send_word({evsd_pkg::TYPE_TIME_HIGH, 28'hFFFFFFF});
      send_word({evsd_pkg::TYPE_EVENT_ON, 6'h15, 11'd100, 11'd200});
      send_word({evsd_pkg::TYPE_TIME_HIGH, 28'h0000000});
      send_word({evsd_pkg::TYPE_TRIGGER, 6'h01, 9'h1FF, 5'h0A, 7'h7F, 1'b0});
      send_word({evsd_pkg::TYPE_TIME_HIGH, 28'h0000000});
      send_word({evsd_pkg::TYPE_TIME_HIGH, 28'h0000123});
   endtask

   // full, empty and odd masks, including masks that look like other words
   task automatic test_vectors();
      send_word({evsd_pkg::TYPE_VECT_ON, 6'h3F, 11'h7FF, 11'h7FF});
      send_word(32'hFFFFFFFF);
      send_word({evsd_pkg::TYPE_VECT_OFF, 6'h00, 11'd0, 11'd0});
      send_word(32'h00000000);
      send_word({evsd_pkg::TYPE_VECT_ON, 6'h2A, 11'd1000, 11'd3});
      send_word({evsd_pkg::TYPE_VECT_OFF, 28'h0000001});
      send_word({evsd_pkg::TYPE_EVENT_OFF, 6'h07, 11'd5, 11'd6});
      send_word({evsd_pkg::TYPE_VECT_OFF, 6'h11, 11'd2047, 11'd0});
      send_word(32'h80000000);
      send_word({evsd_pkg::TYPE_VECT_ON, 6'h22, 11'd9, 11'd2047});
      send_word({evsd_pkg::TYPE_TIME_HIGH, 28'h0000000});
      send_word({evsd_pkg::TYPE_EVENT_ON, 6'h3F, 11'd1, 11'd1});
   endtask

   // mostly well-formed traffic with random content, plus raw noise words
   task automatic test_random_traffic(input int n);
      int                          sent;
      int                          pick;
      logic [evsd_pkg::WORD_W-1:0] mask;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // time base mostly climbs, now and then jumps anywhere
            if ($urandom_range(0, 9) == 0) begin
               stream_base = evsd_pkg::PAY_W'($urandom());
            end else begin
               stream_base = stream_base + evsd_pkg::PAY_W'($urandom_range(1, 64));
            end
            send_word({evsd_pkg::TYPE_TIME_HIGH, stream_base});
            sent++;
         end else if (pick < 37) begin
            send_word({($urandom_range(0, 1) ? evsd_pkg::TYPE_EVENT_ON
                                              : evsd_pkg::TYPE_EVENT_OFF),
                       evsd_pkg::PAY_W'($urandom())});
            sent++;
         end else if (pick < 47) begin
            send_word({evsd_pkg::TYPE_TRIGGER, evsd_pkg::PAY_W'($urandom())});
            sent++;
         end else if (pick < 85) begin
            // vector base followed by its mask
            case ($urandom_range(0, 5))
               0:       mask = evsd_pkg::WORD_W'(1)
                               << $urandom_range(0, evsd_pkg::WORD_W - 1);
               1:       mask = '1;
               2:       mask = '0;
               default: mask = $urandom();
            endcase
            send_word({($urandom_range(0, 1) ? evsd_pkg::TYPE_VECT_ON
                                              : evsd_pkg::TYPE_VECT_OFF),
                       evsd_pkg::PAY_W'($urandom())});
            send_word(mask);
            sent += 2;
         end else begin
            send_word($urandom());
            sent++;
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_word       <= '0;
      send_idle_pct  = 33;
      recv_stall_pct = 69;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_single_words();
      test_time_base();
      test_vectors();
      test_random_traffic(160);
      wait_drain();

      send_idle_pct  = 69;
      recv_stall_pct = 33;
      test_random_traffic(160);
      wait_drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(160);
      wait_drain();

      // let any stray result show up
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
